// ===== rtl/ucd_pkg.sv =====
// Shared types and constants for the undirected cycle detector.
`default_nettype none

package ucd_pkg;

    localparam logic       ACT_EDGE     = 1'b0;
    localparam logic       ACT_FINISH   = 1'b1;
    localparam int         CFG_W        = 7;
    localparam int         VTX_W        = 7;
    localparam logic [6:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_RD_A,
        ST_EDGE_WR_A,
        ST_EDGE_WR_B,
        ST_ROOT,
        ST_ROW_RD,
        ST_SCAN,
        ST_POP,
        ST_TOP_RD,
        ST_DONE
    } t_state;

    // Result of testing one neighbor bit.
    typedef struct packed {
        logic cycle_hit;
        logic open_hit;
    } t_scan_hit;

endpackage

`default_nettype wire

// ===== rtl/ucd_row_ram.sv =====
// Adjacency row memory: one write port, one registered read port.
`default_nettype none

module ucd_row_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ucd_scan_unit.sv =====
// Shared neighbor test: one adjacency bit against the visited mask per cycle.
`default_nettype none

module ucd_scan_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic [MAX_VERTICES-1:0]         i_row,
    input  wire logic [MAX_VERTICES-1:0]         i_visited,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] i_index,
    input  wire logic                            i_check,
    input  wire logic                            i_par_valid,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] i_par,
    output ucd_pkg::t_scan_hit                   o_hit
);

    logic edge_bit;
    logic vis_bit;
    logic is_parent;

    always_comb begin
        edge_bit        = i_row[i_index];
        vis_bit         = i_visited[i_index];
        is_parent       = i_par_valid && (i_index == i_par);
        // back edge to a visited vertex other than the tree parent
        o_hit.cycle_hit = i_check && edge_bit && vis_bit && !is_parent;
        o_hit.open_hit  = edge_bit && !vis_bit;
    end

endmodule

`default_nettype wire

// ===== rtl/undirected_cycle_detect_core.sv =====
// Top level: edge loader, depth-first search sequencer and frame stack.
// Edge item steps: accept, read row a, write a / read b, write b.
// Finish item: per visited vertex one row read plus one bit per cycle over vertex_count
//   bits, once on entry and once per return from a child, all through the single
//   bit-test unit; then a clearing pass over the matrix.
// Reset: a clearing pass over all MAX_VERTICES rows of the adjacency memory, input stalled.
`default_nettype none

module undirected_cycle_detect_core #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration: vertex_count
    input  wire logic                      i_cfg_we,
    input  wire logic [ucd_pkg::CFG_W-1:0] i_cfg_wdata,
    // input items
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_action,
    input  wire logic [ucd_pkg::VTX_W-1:0] i_vertex_a,
    input  wire logic [ucd_pkg::VTX_W-1:0] i_vertex_b,
    // results
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_has_cycle
);

    localparam int IW = $clog2(MAX_VERTICES);      // vertex index
    localparam int VW = $clog2(MAX_VERTICES + 1);  // counts up to MAX_VERTICES

    // state
    ucd_pkg::t_state r_state, n_state;

    logic [ucd_pkg::CFG_W-1:0] r_vcount;
    logic [IW-1:0]             r_clr, n_clr;
    logic [MAX_VERTICES-1:0]   r_visited, n_visited;
    logic [VW-1:0]             r_n, n_n;
    logic [VW-1:0]             r_root, n_root;
    logic [VW-1:0]             r_depth, n_depth;
    logic [VW-1:0]             r_j, n_j;
    logic [IW-1:0]             r_cur, n_cur;
    logic [IW-1:0]             r_par, n_par;
    logic                      r_par_valid, n_par_valid;
    logic                      r_check, n_check;
    logic                      r_found, n_found;
    logic [IW-1:0]             r_next, n_next;
    logic                      r_cycle, n_cycle;
    logic [MAX_VERTICES-1:0]   r_row, n_row;
    logic [IW-1:0]             r_ea, n_ea;
    logic [IW-1:0]             r_eb, n_eb;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_cycle, n_out_cycle;

    // memories and shared unit
    logic                    row_we;
    logic [IW-1:0]           row_waddr;
    logic [MAX_VERTICES-1:0] row_wdata;
    logic [IW-1:0]           row_raddr;
    logic [MAX_VERTICES-1:0] row_rdata;

    logic [IW-1:0] r_stack [MAX_VERTICES];
    logic [IW-1:0] r_stack_q;
    logic          stk_we;
    logic [IW-1:0] stk_waddr;
    logic [IW-1:0] stk_wdata;
    logic [IW-1:0] stk_raddr;

    ucd_pkg::t_scan_hit scan_hit;

    // handshake helpers
    logic in_xfer;
    logic out_free;
    logic edge_ok;
    logic scan_end;
    logic root_end;

    assign o_in_stall  = (r_state != ucd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_has_cycle = r_out_cycle;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    // endpoints outside 1..MAX_VERTICES drop the whole edge
    assign edge_ok  = (i_vertex_a != '0) && (32'(i_vertex_a) <= MAX_VERTICES) &&
                      (i_vertex_b != '0) && (32'(i_vertex_b) <= MAX_VERTICES);
    assign scan_end = (r_j == r_n);
    assign root_end = (r_root >= r_n);

    ucd_row_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MAX_VERTICES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    ucd_scan_unit #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_scan (
        .i_row       (r_row),
        .i_visited   (r_visited),
        .i_index     (r_j[IW-1:0]),
        .i_check     (r_check),
        .i_par_valid (r_par_valid),
        .i_par       (r_par),
        .o_hit       (scan_hit)
    );

    // frame stack: holds the vertex of each open frame
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        r_stack_q <= r_stack[stk_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ucd_pkg::ST_CLEAR: begin
                if (r_clr == IW'(MAX_VERTICES - 1)) begin
                    n_state = ucd_pkg::ST_IDLE;
                end
            end
            ucd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_action == ucd_pkg::ACT_FINISH) begin
                        n_state = ucd_pkg::ST_ROOT;
                    end else if (edge_ok) begin
                        n_state = ucd_pkg::ST_EDGE_RD_A;
                    end
                end
            end
            ucd_pkg::ST_EDGE_RD_A: n_state = ucd_pkg::ST_EDGE_WR_A;
            ucd_pkg::ST_EDGE_WR_A: n_state = ucd_pkg::ST_EDGE_WR_B;
            ucd_pkg::ST_EDGE_WR_B: n_state = ucd_pkg::ST_IDLE;
            ucd_pkg::ST_ROOT: begin
                if (root_end) begin
                    n_state = ucd_pkg::ST_DONE;
                end else if (!r_visited[r_root[IW-1:0]]) begin
                    n_state = ucd_pkg::ST_ROW_RD;
                end
            end
            ucd_pkg::ST_ROW_RD: n_state = ucd_pkg::ST_SCAN;
            ucd_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = r_found ? ucd_pkg::ST_ROW_RD : ucd_pkg::ST_POP;
                end else if (scan_hit.cycle_hit) begin
                    n_state = ucd_pkg::ST_DONE;
                end
            end
            ucd_pkg::ST_POP: begin
                if (r_depth == VW'(1)) begin
                    n_state = ucd_pkg::ST_ROOT;
                end else begin
                    n_state = ucd_pkg::ST_TOP_RD;
                end
            end
            ucd_pkg::ST_TOP_RD: n_state = ucd_pkg::ST_ROW_RD;
            ucd_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ucd_pkg::ST_CLEAR;
                end
            end
            default: n_state = ucd_pkg::ST_CLEAR;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_clr       = r_clr;
        n_visited   = r_visited;
        n_n         = r_n;
        n_root      = r_root;
        n_depth     = r_depth;
        n_j         = r_j;
        n_cur       = r_cur;
        n_par       = r_par;
        n_par_valid = r_par_valid;
        n_check     = r_check;
        n_found     = r_found;
        n_next      = r_next;
        n_cycle     = r_cycle;
        n_row       = r_row;
        n_ea        = r_ea;
        n_eb        = r_eb;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_cycle = r_out_cycle;

        row_we    = 1'b0;
        row_waddr = r_clr;
        row_wdata = '0;
        row_raddr = r_cur;
        stk_we    = 1'b0;
        stk_waddr = r_depth[IW-1:0];
        stk_wdata = r_next;
        stk_raddr = '0;

        case (r_state)
            ucd_pkg::ST_CLEAR: begin
                row_we    = 1'b1;
                row_waddr = r_clr;
                n_clr     = r_clr + IW'(1);
            end
            ucd_pkg::ST_IDLE: begin
                n_ea    = IW'(32'(i_vertex_a) - 1);
                n_eb    = IW'(32'(i_vertex_b) - 1);
                n_root  = '0;
                n_cycle = 1'b0;
                // vertex_count saturates at the matrix size
                if (32'(r_vcount) > MAX_VERTICES) begin
                    n_n = VW'(MAX_VERTICES);
                end else begin
                    n_n = VW'(r_vcount);
                end
            end
            ucd_pkg::ST_EDGE_RD_A: begin
                row_raddr = r_ea;
            end
            ucd_pkg::ST_EDGE_WR_A: begin
                row_we    = 1'b1;
                row_waddr = r_ea;
                row_wdata = row_rdata | (MAX_VERTICES'(1) << r_eb);
                row_raddr = r_eb;
            end
            ucd_pkg::ST_EDGE_WR_B: begin
                row_we    = 1'b1;
                row_waddr = r_eb;
                row_wdata = row_rdata | (MAX_VERTICES'(1) << r_ea);
            end
            ucd_pkg::ST_ROOT: begin
                row_raddr = r_root[IW-1:0];
                if (!root_end) begin
                    if (r_visited[r_root[IW-1:0]]) begin
                        n_root = r_root + VW'(1);
                    end else begin
                        // open a new tree at this root
                        n_visited[r_root[IW-1:0]] = 1'b1;
                        stk_we      = 1'b1;
                        stk_waddr   = '0;
                        stk_wdata   = r_root[IW-1:0];
                        n_depth     = VW'(1);
                        n_cur       = r_root[IW-1:0];
                        n_par_valid = 1'b0;
                        n_check     = 1'b1;
                    end
                end
            end
            ucd_pkg::ST_ROW_RD: begin
                n_row   = row_rdata;
                n_j     = '0;
                n_found = 1'b0;
            end
            ucd_pkg::ST_SCAN: begin
                if (scan_end) begin
                    if (r_found) begin
                        // descend into the lowest unvisited neighbor
                        n_visited[r_next] = 1'b1;
                        stk_we      = 1'b1;
                        stk_waddr   = r_depth[IW-1:0];
                        stk_wdata   = r_next;
                        n_depth     = r_depth + VW'(1);
                        n_par       = r_cur;
                        n_par_valid = 1'b1;
                        n_cur       = r_next;
                        n_check     = 1'b1;
                        row_raddr   = r_next;
                    end
                end else begin
                    if (scan_hit.cycle_hit) begin
                        n_cycle = 1'b1;
                    end
                    if (scan_hit.open_hit && !r_found) begin
                        n_found = 1'b1;
                        n_next  = r_j[IW-1:0];
                    end
                    n_j = r_j + VW'(1);
                end
            end
            ucd_pkg::ST_POP: begin
                n_depth   = r_depth - VW'(1);
                stk_raddr = IW'(r_depth - VW'(2));
                if (r_depth == VW'(1)) begin
                    n_root = r_root + VW'(1);
                end
            end
            ucd_pkg::ST_TOP_RD: begin
                // resume the parent frame: look for its next open neighbor only
                n_cur     = r_stack_q;
                row_raddr = r_stack_q;
                n_check   = 1'b0;
            end
            ucd_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cycle = r_cycle;
                    n_visited   = '0;
                    n_depth     = '0;
                    n_clr       = '0;
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ucd_pkg::ST_CLEAR;
            r_vcount    <= ucd_pkg::VCOUNT_RESET;
            r_clr       <= '0;
            r_visited   <= '0;
            r_root      <= '0;
            r_depth     <= '0;
            r_cycle     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_visited   <= n_visited;
            r_root      <= n_root;
            r_depth     <= n_depth;
            r_cycle     <= n_cycle;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_j         <= n_j;
        r_cur       <= n_cur;
        r_par       <= n_par;
        r_par_valid <= n_par_valid;
        r_check     <= n_check;
        r_found     <= n_found;
        r_next      <= n_next;
        r_row       <= n_row;
        r_ea        <= n_ea;
        r_eb        <= n_eb;
        r_out_cycle <= n_out_cycle;
    end

endmodule

`default_nettype wire

// ===== verif/undirected_cycle_detect_core_checker.sv =====
// Checker for the undirected cycle detector: tracks the graph and compares each verdict.
module undirected_cycle_detect_core_checker #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [ucd_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire logic                      i_action,
    input  wire logic [ucd_pkg::VTX_W-1:0] i_vertex_a,
    input  wire logic [ucd_pkg::VTX_W-1:0] i_vertex_b,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic                      i_has_cycle,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ucd_pkg::*;

    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_bits;
    logic [CFG_W-1:0]        vertex_count;
    logic                    expected_has_cycle [$];
    logic                    want;
    int                      mismatches = 0;

    // Mark vertex k (0-based); flag an edge back to a visited vertex other than
    // the parent (1-based, 0 for a root).
    function automatic logic mark_visit(input int k, input int parent, input int n);
        logic hit;
        int   j;
        hit = 1'b0;
        visited_bits[k] = 1'b1;
        for (j = 0; j < n; j++)
            if (adj_rows[k][j] && visited_bits[j] && (j + 1 != parent))
                hit = 1'b1;
        return hit;
    endfunction

    // Depth-first walk from each unvisited root in ascending order, lowest
    // unvisited neighbor first.
    function automatic logic graph_has_cycle(input logic [CFG_W-1:0] count);
        int   n, root, depth, v, nx, j;
        int   path [MAX_VERTICES];
        logic cycle;
        n = (int'(count) > MAX_VERTICES) ? MAX_VERTICES : int'(count);
        visited_bits = '0;
        cycle = 1'b0;
        for (root = 0; root < n && !cycle; root++) begin
            if (!visited_bits[root]) begin
                cycle = mark_visit(root, 0, n);
                path[0] = root;
                depth = 1;
                while (depth > 0 && !cycle) begin
                    v = path[depth-1];
                    nx = n;
                    for (j = n - 1; j >= 0; j--)
                        if (adj_rows[v][j] && !visited_bits[j])
                            nx = j;
                    if (nx < n) begin
                        cycle = mark_visit(nx, v + 1, n);
                        path[depth] = nx;   // every push is a fresh vertex, depth <= n
                        depth++;
                    end else begin
                        depth--;
                    end
                end
            end
        end
        return cycle;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (adj_rows[r])
                adj_rows[r] = '0;
            vertex_count = VCOUNT_RESET;
            expected_has_cycle.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we)
                vertex_count = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_EDGE) begin
                    if (i_vertex_a >= 1 && i_vertex_a <= MAX_VERTICES &&
                        i_vertex_b >= 1 && i_vertex_b <= MAX_VERTICES) begin
                        adj_rows[i_vertex_a-1][i_vertex_b-1] = 1'b1;
                        adj_rows[i_vertex_b-1][i_vertex_a-1] = 1'b1;
                    end
                end else begin
                    expected_has_cycle.push_back(graph_has_cycle(vertex_count));
                    foreach (adj_rows[r])
                        adj_rows[r] = '0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_has_cycle.size() == 0) begin
                    $error("has_cycle: expected none, actual %0d", i_has_cycle);
                    mismatches++;
                end else begin
                    want = expected_has_cycle.pop_front();
                    if (i_has_cycle !== want) begin
                        $error("has_cycle: expected %0d, actual %0d", want, i_has_cycle);
                        mismatches++;
                    end
                end
            end
            o_pending <= expected_has_cycle.size();
        end
        o_fail_count <= mismatches;
    end

endmodule

// ===== verif/undirected_cycle_detect_core_test.sv =====
// Testbench top for the undirected cycle detector: stimulus, flow control and verdict.
module undirected_cycle_detect_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ucd_pkg::*;

    localparam int MAX_VERTICES = 64;
    localparam int ITEM_GOAL    = 450;
    localparam int RESULT_GOAL  = 40;
    // Matrix clear after a verdict plus an edge in flight.
    localparam int SETTLE_CYCLES = 100;
    // Long receiver hold-off so the block backs up into its input.
    localparam int HOLD_CYCLES = 600;
    // Sized from the worst case per item: a finish on a 64-vertex path plus the
    // matrix clear, the hold-off and a sender gap, over the whole run with margin.
    localparam int CYCLE_LIMIT = 20_000_000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    typedef enum int {
        SHAPE_FOREST,      // tree edges only: acyclic
        SHAPE_FOREST_PLUS, // tree plus one random edge: cycle, duplicate or self loop
        SHAPE_SCATTER,     // random edges inside the span
        SHAPE_NOISE        // only out-of-range endpoints: empty graph at finish
    } t_graph_shape;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    logic             i_action    = ACT_EDGE;
    logic [VTX_W-1:0] i_vertex_a  = '0;
    logic [VTX_W-1:0] i_vertex_b  = '0;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic             o_has_cycle;

    int fail_count;
    int pending;
    int item_count   = 0;   // transfers the block acts on (ignored edges left out)
    int finish_count = 0;
    int burst_left   = 0;
    bit random_phase = 1'b0;

    undirected_cycle_detect_core #(
        .MAX_VERTICES(MAX_VERTICES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_has_cycle (o_has_cycle)
    );

    undirected_cycle_detect_core_checker #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_vertex_a   (i_vertex_a),
        .i_vertex_b   (i_vertex_b),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_has_cycle  (o_has_cycle),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Offer one item and hold it until the transfer. Called at a rising edge;
    // returns at the edge of the transfer. The sender works in bursts: when a
    // burst runs out, valid drops for a random gap before the next one.
    task automatic send_item(input logic act, input int a, input int b);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_vertex_a <= VTX_W'(a);
        i_vertex_b <= VTX_W'(b);
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        burst_left--;
        if (act == ACT_FINISH) begin
            finish_count++;
            item_count++;
        end else if (a >= 1 && a <= MAX_VERTICES && b >= 1 && b <= MAX_VERTICES) begin
            item_count++;
        end
    endtask

    // Edge in random orientation, now and then preceded by a malformed edge
    // (endpoint 0 or beyond MAX_VERTICES) that the block must drop.
    task automatic send_edge(input int a, input int b);
        if ($urandom_range(0, 9) == 0)
            send_item(ACT_EDGE, $urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
                      $urandom_range(0, 127));
        if ($urandom_range(0, 1))
            send_item(ACT_EDGE, b, a);
        else
            send_item(ACT_EDGE, a, b);
    endtask

    // Drop valid, wait for every outstanding verdict, then let the matrix
    // clear finish before anything else touches the block.
    task automatic settle();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input int value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One graph over vertices 1..span, closed by a finish with junk endpoints.
    task automatic send_random_graph(input int span);
        t_graph_shape shape;
        int           k, count;
        shape = t_graph_shape'($urandom_range(0, 3));
        case (shape)
            SHAPE_FOREST, SHAPE_FOREST_PLUS: begin
                for (k = 2; k <= span; k++)
                    if ($urandom_range(0, 4) != 0)
                        send_edge(k, $urandom_range(1, k - 1));
                if (shape == SHAPE_FOREST_PLUS)
                    send_edge($urandom_range(1, span), $urandom_range(1, span));
            end
            SHAPE_SCATTER: begin
                count = $urandom_range(0, 8);
                for (k = 0; k < count; k++)
                    send_edge($urandom_range(1, span), $urandom_range(1, span));
            end
            default: begin
                count = $urandom_range(0, 3);
                for (k = 0; k < count; k++)
                    send_item(ACT_EDGE, $urandom_range(65, 127), $urandom_range(0, 127));
            end
        endcase
        send_item(ACT_FINISH, $urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    // Receiver: stall pattern that changes mode every so often, plus one long
    // hold-off once results meet a busy sender in the random part.
    initial begin : receiver
        t_stall_mode mode;
        int          mode_left, hold_left;
        bit          hold_done;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && random_phase && i_in_valid && o_out_valid) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int n, span, graphs, k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset vertex count (64). Malformed endpoints are
        // dropped, a reversed duplicate collapses: one edge, no cycle.
        send_item(ACT_EDGE, 0, 5);
        send_item(ACT_EDGE, 65, 3);
        send_item(ACT_EDGE, 127, 127);
        send_item(ACT_EDGE, 1, 64);
        send_item(ACT_EDGE, 64, 1);
        send_item(ACT_FINISH, 127, 0);
        // Self loop alone is a cycle.
        send_item(ACT_EDGE, 7, 7);
        send_item(ACT_FINISH, 0, 127);
        // Triangle.
        send_item(ACT_EDGE, 1, 2);
        send_item(ACT_EDGE, 2, 3);
        send_item(ACT_EDGE, 3, 1);
        send_item(ACT_FINISH, 0, 0);
        // Empty graph right after a cleared one.
        send_item(ACT_FINISH, 64, 64);
        // Triangle through vertex 4 while only three vertices are in use.
        write_vertex_count(3);
        send_item(ACT_EDGE, 1, 2);
        send_item(ACT_EDGE, 2, 4);
        send_item(ACT_EDGE, 4, 1);
        send_item(ACT_FINISH, 1, 1);
        // Zero vertices: nothing is searched, not even a self loop.
        write_vertex_count(0);
        send_item(ACT_EDGE, 1, 1);
        send_item(ACT_FINISH, 0, 0);
        // Count beyond MAX_VERTICES saturates; triangle on the top vertices.
        write_vertex_count(127);
        send_item(ACT_EDGE, 62, 63);
        send_item(ACT_EDGE, 63, 64);
        send_item(ACT_EDGE, 64, 62);
        send_item(ACT_FINISH, 127, 127);

        random_phase <= 1'b1;

        // Slowest search: one path over all 64 vertices, no cycle.
        write_vertex_count(MAX_VERTICES);
        for (k = 1; k < MAX_VERTICES; k++)
            send_edge(k, k + 1);
        send_item(ACT_FINISH, $urandom_range(0, 127), $urandom_range(0, 127));

        // Random phases: new vertex count, then a few graphs. Most graphs stay
        // small; some reach past the vertex count so those edges are stored
        // but must not affect the verdict.
        while (item_count < ITEM_GOAL || finish_count < RESULT_GOAL) begin
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = 1;
                2:       n = MAX_VERTICES;
                3:       n = $urandom_range(MAX_VERTICES + 1, 127);
                default: n = $urandom_range(2, 12);
            endcase
            write_vertex_count(n);
            if (n < 2)
                span = $urandom_range(2, 4);
            else if (n >= MAX_VERTICES)
                span = $urandom_range(2, 16);
            else
                span = ($urandom_range(0, 3) == 0) ? n + 2 : n;
            graphs = $urandom_range(2, 5);
            for (k = 0; k < graphs; k++)
                send_random_graph(span);
        end

        settle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
